// File: hdl/socd_pkg.sv
`default_nettype none

package socd_pkg;

    localparam int SCREEN_WIDTH  = 224;
    localparam int SCREEN_HEIGHT = 256;
    localparam int GFX_DEPTH     = 2048;
    localparam int GFX_AW        = $clog2(GFX_DEPTH);

    localparam logic [7:0]  SPRITE_SIZE  = 8'd32;
    localparam logic [7:0]  VISIBLE_ROWS = 8'he0;
    localparam logic [15:0] NO_COLLISION = 16'hffff;
    localparam logic [3:0]  STATUS_HIT   = 4'h8;
    localparam logic [3:0]  STATUS_NONE  = 4'h7;

    typedef enum logic [2:0] {
        OP_SPRITE_REG  = 3'd0,
        OP_GFX_LOAD    = 3'd1,
        OP_CONTROL     = 3'd2,
        OP_FRAME_START = 3'd3,
        OP_PIXEL       = 3'd4,
        OP_COLL_READ   = 3'd5
    } t_op;

    localparam logic [1:0] REG_CODE_COLOR = 2'd0;
    localparam logic [1:0] REG_POS_X      = 2'd1;
    localparam logic [1:0] REG_POS_Y      = 2'd2;

    localparam logic [1:0] RD_LOW    = 2'd0;
    localparam logic [1:0] RD_MID    = 2'd1;
    localparam logic [1:0] RD_HIGH   = 2'd2;
    localparam logic [1:0] RD_STATUS = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic              we;
        logic [GFX_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [GFX_AW-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic       valid;
        t_op        op;
        logic       sprite_on;
        logic [2:0] bit_sel;
        logic [4:0] bg_pen;
        logic [3:0] color;
        logic [4:0] px_hi;
        logic [4:0] py_hi;
        logic [1:0] read_offset;
    } t_stage;

    typedef struct packed {
        logic s1_valid;
        t_op  s1_op;
    } t_back_stat;

endpackage

`default_nettype wire

// File: hdl/socd_in_if.sv
`default_nettype none

interface socd_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [1:0] reg_index;
    logic [7:0] write_value;
    logic [10:0] gfx_address;
    logic       flip_screen;
    logic       clear_collision;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [4:0] background_pen;
    logic [1:0] read_offset;

    modport source (
        output valid, operation, reg_index, write_value, gfx_address, flip_screen,
               clear_collision, pixel_x, pixel_y, background_pen, read_offset,
        input  ready
    );

    modport sink (
        input  valid, operation, reg_index, write_value, gfx_address, flip_screen,
               clear_collision, pixel_x, pixel_y, background_pen, read_offset,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/socd_out_if.sv
`default_nettype none

interface socd_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [4:0] pixel_pen;
    logic [3:0] read_value;

    modport source (
        output valid, result_kind, pixel_pen, read_value,
        input  ready
    );

    modport sink (
        input  valid, result_kind, pixel_pen, read_value,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/socd_ram.sv
`default_nettype none

module socd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/socd_front.sv
`default_nettype none

module socd_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    socd_in_if.sink          i_req,
    input  wire logic        i_s1_free,
    output socd_pkg::t_ram_req o_ram,
    output socd_pkg::t_stage o_stage,
    output logic             o_clear_flag
);
    import socd_pkg::*;

    logic [7:0] r_code_color;
    logic [7:0] r_pos_x;
    logic [7:0] r_pos_y;
    logic       r_flip;
    logic       r_clear;

    logic        w_accept;
    t_op         w_op;
    logic [7:0]  w_top_row;
    logic [7:0]  w_dy;
    logic [7:0]  w_dx;
    logic [4:0]  w_gx;
    logic [4:0]  w_gy;
    logic        w_on_screen;
    logic        w_in_box;
    logic [10:0] w_full_addr;

    assign w_accept     = i_req.valid && i_s1_free && i_rst_n;
    assign i_req.ready  = i_s1_free && i_rst_n;
    assign w_op         = t_op'(i_req.operation);
    assign o_clear_flag = r_clear;

    always_comb begin
        w_top_row   = r_flip ? r_pos_y : r_pos_y - SPRITE_SIZE;
        w_dy        = i_req.pixel_y - w_top_row;
        w_dx        = i_req.pixel_x - r_pos_x;
        w_gx        = ~w_dx[4:0];
        w_gy        = ~w_dy[4:0];
        w_on_screen = (9'(i_req.pixel_x) < 9'(SCREEN_WIDTH))
                   && (9'(i_req.pixel_y) < 9'(SCREEN_HEIGHT));
        w_in_box    = (w_dy[7:5] == 3'd0) && (w_dx[7:5] == 3'd0)
                   && (i_req.pixel_y < VISIBLE_ROWS);
        w_full_addr = {r_code_color[3:0], w_gx[4:3], w_gy};

        o_ram.we    = w_accept && (w_op == OP_GFX_LOAD);
        o_ram.waddr = i_req.gfx_address[GFX_AW-1:0];
        o_ram.wdata = i_req.write_value;
        o_ram.re    = w_accept && (w_op == OP_PIXEL);
        o_ram.raddr = w_full_addr[GFX_AW-1:0];

        o_stage.valid       = w_accept;
        o_stage.op          = w_op;
        o_stage.sprite_on   = w_on_screen && w_in_box;
        o_stage.bit_sel     = w_gx[2:0];
        o_stage.bg_pen      = i_req.background_pen;
        o_stage.color       = r_code_color[7:4];
        o_stage.px_hi       = ~i_req.pixel_x[7:3];
        o_stage.py_hi       = ~i_req.pixel_y[7:3];
        o_stage.read_offset = i_req.read_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_color <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_flip       <= 1'b0;
            r_clear      <= 1'b1;
        end else if (w_accept) begin
            case (w_op)
                OP_SPRITE_REG: begin
                    case (i_req.reg_index)
                        REG_CODE_COLOR: r_code_color <= i_req.write_value;
                        REG_POS_X:      r_pos_x      <= i_req.write_value;
                        REG_POS_Y:      r_pos_y      <= i_req.write_value;
                        default: begin
                        end
                    endcase
                end
                OP_CONTROL: begin
                    r_flip  <= i_req.flip_screen;
                    r_clear <= i_req.clear_collision;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/socd_back.sv
`default_nettype none

module socd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  socd_pkg::t_stage      i_stage,
    input  wire logic [7:0]       i_rdata,
    input  wire logic             i_clear_flag,
    output logic                  o_s1_free,
    output socd_pkg::t_back_stat  o_stat,
    socd_out_if.source            o_rsp
);
    import socd_pkg::*;

    t_stage      r_s1;
    logic [15:0] r_coll_addr;
    logic        r_out_valid;
    logic        r_out_kind;
    logic [4:0]  r_out_pen;
    logic [3:0]  r_out_value;

    logic        w_has_result;
    logic        w_go;
    logic        w_sprite_bit;
    logic        w_collide;
    logic [4:0]  w_pen;
    logic [15:0] w_new_addr;
    logic [15:0] w_eff_addr;
    logic        w_hit;
    logic [3:0]  w_value;

    always_comb begin
        w_has_result = (r_s1.op == OP_PIXEL) || (r_s1.op == OP_COLL_READ);
        w_go         = r_s1.valid && (!w_has_result || !r_out_valid || o_rsp.ready);
        o_s1_free    = !r_s1.valid || w_go;

        w_sprite_bit = r_s1.sprite_on && i_rdata[r_s1.bit_sel];
        w_collide    = w_sprite_bit && r_s1.bg_pen[0];
        w_pen        = w_sprite_bit ? {r_s1.color, 1'b1} : r_s1.bg_pen;
        w_new_addr   = 16'({r_s1.py_hi, r_s1.px_hi}) + 16'd1;

        w_eff_addr = i_clear_flag ? NO_COLLISION : r_coll_addr;
        w_hit      = w_eff_addr != NO_COLLISION;
        case (r_s1.read_offset)
            RD_LOW:    w_value = w_hit ? w_eff_addr[3:0]  : 4'd0;
            RD_MID:    w_value = w_hit ? w_eff_addr[7:4]  : 4'd0;
            RD_HIGH:   w_value = w_hit ? w_eff_addr[11:8] : 4'd0;
            RD_STATUS: w_value = w_hit ? STATUS_HIT : STATUS_NONE;
            default:   w_value = 4'd0;
        endcase

        o_stat.s1_valid = r_s1.valid;
        o_stat.s1_op    = r_s1.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid  <= 1'b0;
            r_coll_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s1_free) begin
                r_s1 <= i_stage;
            end
            if (w_go && w_has_result) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_go) begin
                case (r_s1.op)
                    OP_FRAME_START: r_coll_addr <= NO_COLLISION;
                    OP_PIXEL: begin
                        if (w_collide) begin
                            r_coll_addr <= w_new_addr;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_has_result) begin
            if (r_s1.op == OP_PIXEL) begin
                r_out_kind  <= KIND_PIXEL;
                r_out_pen   <= w_pen;
                r_out_value <= 4'd0;
            end else begin
                r_out_kind  <= KIND_READ;
                r_out_pen   <= 5'd0;
                r_out_value <= w_value;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out_kind;
    assign o_rsp.pixel_pen   = r_out_pen;
    assign o_rsp.read_value  = r_out_value;

endmodule

`default_nettype wire

// File: hdl/sprite_overlay_collision_detector_core.sv
// Sprite overlay and collision detector.
// Requests arrive on i_req: sprite register writes, graphics loads, control,
// frame start, pixels and collision reads. Pixels and collision reads each
// give one result on o_rsp; all other requests give none.
// The block takes one request per clock while i_req.ready is high. A result
// is built in two registered steps after its request is accepted: the
// graphics store read is registered at the accepting edge, and the output
// register loads when the read stage passes the request on.
// Collisions are latched in request order, so a later colliding pixel
// replaces an earlier one, and a collision read sees every earlier pixel.
// Reset clears the sprite registers, the flip flag and the collision address
// and sets the collision-clear flag; the graphics store is not cleared and
// must be loaded before any sprite is drawn. i_req.ready is low during reset.
// When the receiver stalls, the result waits in the output register. Requests
// that give no result keep flowing, and one more pixel or collision read can
// still be taken into the read stage; after that, i_req.ready falls until the
// result is taken.
`default_nettype none

module sprite_overlay_collision_detector_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    socd_in_if.sink   i_req,
    socd_out_if.source o_rsp
);
    import socd_pkg::*;

    t_ram_req   w_ram;
    t_stage     w_stage;
    t_back_stat w_stat;
    logic [7:0] w_rdata;
    logic       w_s1_free;
    logic       w_clear_flag;

    socd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_s1_free    (w_s1_free),
        .o_ram        (w_ram),
        .o_stage      (w_stage),
        .o_clear_flag (w_clear_flag)
    );

    socd_ram #(
        .WIDTH (8),
        .DEPTH (GFX_DEPTH)
    ) u_gfx (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    socd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (w_stage),
        .i_rdata      (w_rdata),
        .i_clear_flag (w_clear_flag),
        .o_s1_free    (w_s1_free),
        .o_stat       (w_stat),
        .o_rsp        (o_rsp)
    );

`ifndef SYNTH
    a_ram_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram.we && w_ram.re))
        else $error("graphics load and pixel read issued together");

    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram.re |=> (w_stat.s1_valid && (w_stat.s1_op == OP_PIXEL)))
        else $error("pixel read data arrived without its pixel in the read stage");

    a_free_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_stat.s1_valid |-> w_s1_free)
        else $error("empty read stage refused a request");
`endif

endmodule

`default_nettype wire

// File: tb/socd_overlay_checker.sv
`default_nettype none

module socd_overlay_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    socd_in_if        i_req_mon,
    socd_out_if       i_rsp_mon,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import socd_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [4:0] pen;
        logic [3:0] nibble;
    } t_socd_result;

    t_socd_result expected_results [$];

    logic [7:0]  spr_regs [3];
    logic [7:0]  gfx_mem [GFX_DEPTH];
    logic        flip_q;
    logic        clear_q;
    logic [15:0] coll_addr_q;

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // Latches the collision tile address as a side effect.
    function automatic logic [4:0] overlay_pen(input logic [7:0] px, input logic [7:0] py,
                                               input logic [4:0] bg);
        logic [7:0] top_row;
        logic [7:0] dy;
        logic [7:0] dx;
        logic [7:0] gy;
        logic [7:0] gx;
        logic [7:0] gbyte;
        top_row = flip_q ? spr_regs[REG_POS_Y] : spr_regs[REG_POS_Y] - SPRITE_SIZE;
        dy = py - top_row;
        dx = px - spr_regs[REG_POS_X];
        if (int'(px) >= SCREEN_WIDTH || int'(py) >= SCREEN_HEIGHT) return bg;
        if (dy >= SPRITE_SIZE || dx >= SPRITE_SIZE || py >= VISIBLE_ROWS) return bg;
        gy = 8'd31 - dy;
        gx = 8'd31 - dx;
        gbyte = gfx_mem[int'({spr_regs[REG_CODE_COLOR][3:0], gx[4:3], gy[4:0]}) % GFX_DEPTH];
        if (!gbyte[gx[2:0]]) return bg;
        if (bg[0]) coll_addr_q = 16'({~py[7:3], ~px[7:3]}) + 16'd1;
        return {spr_regs[REG_CODE_COLOR][7:4], 1'b1};
    endfunction

    function automatic logic [3:0] collision_nibble(input logic [1:0] sel);
        logic [15:0] addr;
        logic        hit;
        addr = clear_q ? NO_COLLISION : coll_addr_q;
        hit = addr != NO_COLLISION;
        case (sel)
            RD_LOW:  return hit ? addr[3:0] : 4'd0;
            RD_MID:  return hit ? addr[7:4] : 4'd0;
            RD_HIGH: return hit ? addr[11:8] : 4'd0;
            default: return hit ? STATUS_HIT : STATUS_NONE;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_socd_result got;
        t_socd_result want;
        if (!i_rst_n) begin
            spr_regs = '{8'd0, 8'd0, 8'd0};
            flip_q = 1'b0;
            clear_q = 1'b1;
            coll_addr_q = 16'd0;
            expected_results.delete();
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got = '{i_rsp_mon.result_kind, i_rsp_mon.pixel_pen, i_rsp_mon.read_value};
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with nothing pending: kind %0d pen %0d value %0d",
                        got.kind, got.pen, got.nibble));
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("result_kind got %0d want %0d",
                                                  got.kind, want.kind));
                    if (got.pen !== want.pen)
                        report_mismatch($sformatf("pixel_pen got %0d want %0d",
                                                  got.pen, want.pen));
                    if (got.nibble !== want.nibble)
                        report_mismatch($sformatf("read_value got %0d want %0d",
                                                  got.nibble, want.nibble));
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                case (i_req_mon.operation)
                    OP_SPRITE_REG: begin
                        case (i_req_mon.reg_index)
                            REG_CODE_COLOR, REG_POS_X, REG_POS_Y:
                                spr_regs[i_req_mon.reg_index] = i_req_mon.write_value;
                            default: ;
                        endcase
                    end
                    OP_GFX_LOAD: begin
                        gfx_mem[int'(i_req_mon.gfx_address) % GFX_DEPTH] =
                            i_req_mon.write_value;
                    end
                    OP_CONTROL: begin
                        flip_q = i_req_mon.flip_screen;
                        clear_q = i_req_mon.clear_collision;
                    end
                    OP_FRAME_START: begin
                        coll_addr_q = NO_COLLISION;
                    end
                    OP_PIXEL: begin
                        expected_results.push_back('{KIND_PIXEL,
                            overlay_pen(i_req_mon.pixel_x, i_req_mon.pixel_y,
                                        i_req_mon.background_pen), 4'd0});
                    end
                    OP_COLL_READ: begin
                        expected_results.push_back('{KIND_READ, 5'd0,
                            collision_nibble(i_req_mon.read_offset)});
                    end
                    default: ;
                endcase
            end
        end
        o_pending = expected_results.size();
    end

endmodule

`default_nettype wire

// File: tb/tb_sprite_overlay_collision_detector_core.sv
`default_nettype none

module tb_sprite_overlay_collision_detector_core;
    timeunit 1ns;
    timeprecision 1ps;
    import socd_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam logic [1:0] REG_SPARE  = 2'd3;

    localparam int ITEMS       = 400;
    localparam int CALM_TAIL   = 60;
    localparam int SQUEEZE_AT  = 150;
    localparam int SQUEEZE_LEN = 80;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  reg_index;
        logic [7:0]  wv;
        logic [10:0] ga;
        logic        flip;
        logic        clr;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [4:0]  bg;
        logic [1:0]  ro;
    } t_socd_item;

    logic i_clk;
    logic i_rst_n;

    socd_in_if  req_if ();
    socd_out_if rsp_if ();

    int fail_cnt;
    int pending_cnt;
    int checked_cnt;

    sprite_overlay_collision_detector_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    socd_overlay_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_if),
        .i_rsp_mon    (rsp_if),
        .o_fail_count (fail_cnt),
        .o_pending    (pending_cnt),
        .o_checked    (checked_cnt)
    );

    logic [7:0] sh_regs [3];
    logic       sh_flip;
    bit         gfx_loaded [GFX_DEPTH];
    int         issued;
    int         pixel_cnt;
    int         read_cnt;
    int         cycles;
    bit         squeezed;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("sprite_overlay_collision_detector_core verification failed");
        $finish;
    end

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!squeezed && issued >= SQUEEZE_AT) begin
                squeezed = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (SQUEEZE_LEN) @(posedge i_clk);
            end else if (issued >= ITEMS - CALM_TAIL || $urandom_range(0, 3) != 0) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(posedge i_clk);
            end
        end
    end

    function automatic t_socd_item noise_fields(input logic [2:0] op);
        t_socd_item it;
        it.op = op;
        it.reg_index = 2'($urandom);
        it.wv = 8'($urandom);
        it.ga = 11'($urandom);
        it.flip = 1'($urandom);
        it.clr = 1'($urandom);
        it.px = 8'($urandom);
        it.py = 8'($urandom);
        it.bg = 5'($urandom);
        it.ro = 2'($urandom);
        return it;
    endfunction

    // Tells whether a pixel would fetch sprite graphics, and from where.
    function automatic bit sprite_fetch(input logic [7:0] px, input logic [7:0] py,
                                        output logic [10:0] addr);
        logic [7:0] top_row;
        logic [7:0] dy;
        logic [7:0] dx;
        logic [7:0] gy;
        logic [7:0] gx;
        top_row = sh_flip ? sh_regs[REG_POS_Y] : sh_regs[REG_POS_Y] - SPRITE_SIZE;
        dy = py - top_row;
        dx = px - sh_regs[REG_POS_X];
        addr = '0;
        if (int'(px) >= SCREEN_WIDTH || dy >= SPRITE_SIZE || dx >= SPRITE_SIZE ||
            py >= VISIBLE_ROWS) return 1'b0;
        gy = 8'd31 - dy;
        gx = 8'd31 - dx;
        addr = {sh_regs[REG_CODE_COLOR][3:0], gx[4:3], gy[4:0]};
        return 1'b1;
    endfunction

    task automatic send(input t_socd_item it);
        req_if.valid <= 1'b1;
        req_if.operation <= it.op;
        req_if.reg_index <= it.reg_index;
        req_if.write_value <= it.wv;
        req_if.gfx_address <= it.ga;
        req_if.flip_screen <= it.flip;
        req_if.clear_collision <= it.clr;
        req_if.pixel_x <= it.px;
        req_if.pixel_y <= it.py;
        req_if.background_pen <= it.bg;
        req_if.read_offset <= it.ro;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        case (it.op)
            OP_SPRITE_REG: if (it.reg_index != REG_SPARE) sh_regs[it.reg_index] = it.wv;
            OP_GFX_LOAD:   gfx_loaded[int'(it.ga) % GFX_DEPTH] = 1'b1;
            OP_CONTROL:    sh_flip = it.flip;
            OP_PIXEL:      pixel_cnt++;
            OP_COLL_READ:  read_cnt++;
            default: ;
        endcase
        if (!(it.op == OP_SPARE_A || it.op == OP_SPARE_B ||
              (it.op == OP_SPRITE_REG && it.reg_index == REG_SPARE)))
            issued++;
        if (issued < ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
        t_socd_item it;
        it = noise_fields(OP_SPRITE_REG);
        it.reg_index = idx;
        it.wv = val;
        send(it);
    endtask

    task automatic gfx_load(input logic [10:0] addr, input logic [7:0] val);
        t_socd_item it;
        it = noise_fields(OP_GFX_LOAD);
        it.ga = addr;
        it.wv = val;
        send(it);
    endtask

    task automatic control(input logic flip, input logic clr);
        t_socd_item it;
        it = noise_fields(OP_CONTROL);
        it.flip = flip;
        it.clr = clr;
        send(it);
    endtask

    task automatic coll_read(input logic [1:0] off);
        t_socd_item it;
        it = noise_fields(OP_COLL_READ);
        it.ro = off;
        send(it);
    endtask

    // Loads the graphics byte first when the pixel would hit an unwritten entry.
    task automatic pixel_item(input logic [7:0] px, input logic [7:0] py,
                              input logic [4:0] bg, input logic [7:0] fill);
        t_socd_item it;
        logic [10:0] fa;
        if (sprite_fetch(px, py, fa) && !gfx_loaded[fa]) gfx_load(fa, fill);
        it = noise_fields(OP_PIXEL);
        it.px = px;
        it.py = py;
        it.bg = bg;
        send(it);
    endtask

    initial begin
        logic [7:0] top_row;
        logic [2:0] op;
        int         n;
        req_if.valid <= 1'b0;
        req_if.operation <= OP_SPRITE_REG;
        req_if.reg_index <= REG_CODE_COLOR;
        req_if.write_value <= 8'd0;
        req_if.gfx_address <= 11'd0;
        req_if.flip_screen <= 1'b0;
        req_if.clear_collision <= 1'b0;
        req_if.pixel_x <= 8'd0;
        req_if.pixel_y <= 8'd0;
        req_if.background_pen <= 5'd0;
        req_if.read_offset <= RD_LOW;
        i_rst_n <= 1'b0;
        sh_regs = '{8'd0, 8'd0, 8'd0};
        sh_flip = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // After reset the clear flag hides the zero collision address.
        coll_read(RD_STATUS);
        coll_read(RD_LOW);
        control(1'b0, 1'b0);
        coll_read(RD_STATUS);
        control(1'b0, 1'b0);
        coll_read(RD_STATUS);
        send(noise_fields(OP_FRAME_START));
        coll_read(RD_STATUS);
        reg_write(REG_CODE_COLOR, 8'hf3);
        reg_write(REG_POS_X, 8'd0);
        reg_write(REG_POS_Y, 8'd32);
        gfx_load(11'h7ff, 8'ha5);
        pixel_item(8'd0, 8'd0, 5'd1, 8'hff);
        pixel_item(8'd31, 8'd31, 5'd31, 8'hff);
        pixel_item(8'd32, 8'd0, 5'd1, 8'hff);
        // The sprite wraps past the right edge; columns past the screen stay background.
        reg_write(REG_POS_X, 8'd240);
        pixel_item(8'd245, 8'd10, 5'd1, 8'hff);
        pixel_item(8'd5, 8'd10, 5'd1, 8'hff);
        coll_read(RD_LOW);
        coll_read(RD_MID);
        coll_read(RD_HIGH);
        coll_read(RD_STATUS);
        reg_write(REG_SPARE, 8'h55);
        send(noise_fields(OP_SPARE_A));
        send(noise_fields(OP_SPARE_B));
        control(1'b1, 1'b0);
        reg_write(REG_POS_Y, 8'hd0);
        pixel_item(8'd7, 8'he2, 5'd1, 8'hff);
        pixel_item(8'd7, 8'hd5, 5'd0, 8'hff);
        control(1'b0, 1'b1);
        coll_read(RD_STATUS);

        while (issued < ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 7) != 0) send(noise_fields(OP_FRAME_START));
                if ($urandom_range(0, 5) != 0) control(1'($urandom), $urandom_range(0, 5) == 0);
                if ($urandom_range(0, 2) != 0) reg_write(REG_CODE_COLOR, 8'($urandom));
                if ($urandom_range(0, 2) != 0) reg_write(REG_POS_X, 8'($urandom));
                if ($urandom_range(0, 2) != 0) reg_write(REG_POS_Y, 8'($urandom));
                if ($urandom_range(0, 9) == 0) reg_write(REG_SPARE, 8'($urandom));
                n = $urandom_range(6, 24);
                repeat (n) begin
                    top_row = sh_flip ? sh_regs[REG_POS_Y] : sh_regs[REG_POS_Y] - SPRITE_SIZE;
                    if ($urandom_range(0, 4) == 0)
                        pixel_item(8'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
                    else
                        pixel_item(sh_regs[REG_POS_X] + 8'($urandom_range(0, 39)) - 8'd4,
                                   top_row + 8'($urandom_range(0, 39)) - 8'd4,
                                   5'($urandom), 8'($urandom));
                end
                n = $urandom_range(1, 4);
                repeat (n) coll_read(2'($urandom));
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    op = 3'($urandom);
                    if (op == OP_PIXEL)
                        pixel_item(8'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
                    else
                        send(noise_fields(op));
                end
            end
        end
        req_if.valid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d requests sent: %0d pixels and %0d collision reads over random frames",
                 issued, pixel_cnt, read_cnt);
        $display("%0d results compared, including a %0d-cycle output stall",
                 checked_cnt, SQUEEZE_LEN);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("sprite_overlay_collision_detector_core verification clean");
        end else begin
            $display("sprite_overlay_collision_detector_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hdl/socd_pkg.sv
hdl/socd_in_if.sv
hdl/socd_out_if.sv
hdl/socd_ram.sv
hdl/socd_front.sv
hdl/socd_back.sv
hdl/sprite_overlay_collision_detector_core.sv
tb/socd_overlay_checker.sv
tb/tb_sprite_overlay_collision_detector_core.sv
